// File: hdl/skfd_pkg.sv
// ----------------------------------------------------------------------------
// skfd_pkg: shared types and constants of the key-file destuffer
// Terminator key, stuff character, length width and the command/status
// structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package skfd_pkg;

  localparam int LENGTH_BITS = 24;
  localparam int KEY_LEN     = 12;
  localparam int OUT_LEN_W   = 24;

  localparam logic [7:0] STUFF_CHAR = 8'h58;  // 'X'
  localparam logic [3:0] KEY_LAST   = 4'(KEY_LEN - 1);

  // terminator key characters, first to last
  localparam logic [7:0] KEY_CHARS [KEY_LEN] = '{
    8'h66, 8'h74, 8'h5F, 8'h53, 8'h74, 8'h55,
    8'h66, 8'h46, 8'h5F, 8'h6B, 8'h65, 8'h79
  };

  // Controller -> datapath
  typedef struct packed {
    logic accept;       // latch the input beat and update the match count
    logic load_replay;  // emit the next replayed key character
    logic load_byte;    // emit the held byte
    logic load_term;    // emit the file end / stream cut beat
  } skfd_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic is_eos;       // input beat closes the stream
    logic full_match;   // input byte completes the key
    logic partial;      // input byte extends the key prefix
    logic stuff;        // stuffing X after eleven key characters
    logic m_nz;         // a key prefix is pending
    logic replay_done;  // current replay beat is the last one
    logic stuffed;      // held item was a stuff X (nothing follows replay)
    logic out_busy;     // output register holds a beat
  } skfd_sts_t;

endpackage

// File: hdl/skfd_dpath.sv
// ----------------------------------------------------------------------------
// skfd_dpath: datapath of the key-file destuffer
// Match counter, delivered-byte counter, replay index, held input and the
// output register.
// ----------------------------------------------------------------------------
module skfd_dpath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  skfd_pkg::skfd_cmd_t                 cmd_i,
  output skfd_pkg::skfd_sts_t                 sts_o,
  input  logic [7:0]                          data_byte_i,
  input  logic                                end_of_stream_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [7:0]                          out_byte_o,
  output logic                                byte_valid_o,
  output logic                                file_end_o,
  output logic                                stream_cut_o,
  output logic [skfd_pkg::OUT_LEN_W-1:0]      file_length_o,
  output logic                                last_o
);
  import skfd_pkg::*;

  logic [3:0]             m_q, m_d;
  logic [3:0]             len_q, len_d;
  logic [3:0]             idx_q, idx_d;
  logic [LENGTH_BITS-1:0] cnt_q, cnt_d;
  logic [7:0]             byte_q;
  logic                   cut_q, stuffed_q;

  logic                   ovld_q, ovld_d;
  logic [7:0]             obyte_q, obyte_d;
  logic                   obv_q, obv_d, ofe_q, ofe_d, ocut_q, ocut_d, olast_q, olast_d;
  logic [OUT_LEN_W-1:0]   olen_q, olen_d;

  logic                   hit, done;
  logic [LENGTH_BITS-1:0] cnt_inc;

  assign hit     = (data_byte_i == KEY_CHARS[m_q]);
  assign done    = (idx_q == 4'(len_q - 4'd1));
  assign cnt_inc = (cnt_q == '1) ? cnt_q : cnt_q + LENGTH_BITS'(1);

  always_comb begin
    sts_o             = '0;
    sts_o.is_eos      = end_of_stream_i;
    sts_o.full_match  = hit && (m_q == KEY_LAST);
    sts_o.partial     = hit && (m_q != KEY_LAST);
    sts_o.stuff       = (data_byte_i == STUFF_CHAR) && (m_q == KEY_LAST);
    sts_o.m_nz        = (m_q != 4'd0);
    sts_o.replay_done = done;
    sts_o.stuffed     = stuffed_q;
    sts_o.out_busy    = ovld_q;
  end

  always_comb begin
    m_d     = m_q;
    len_d   = len_q;
    idx_d   = idx_q;
    cnt_d   = cnt_q;
    ovld_d  = ovld_q && !out_ready_i;
    obyte_d = obyte_q;
    obv_d   = obv_q;
    ofe_d   = ofe_q;
    ocut_d  = ocut_q;
    olast_d = olast_q;
    olen_d  = olen_q;

    if (cmd_i.accept) begin
      len_d = m_q;
      idx_d = 4'd0;
      m_d   = (!end_of_stream_i && hit && (m_q != KEY_LAST)) ? 4'(m_q + 4'd1) : 4'd0;
    end

    if (cmd_i.load_replay) begin
      ovld_d  = 1'b1;
      obyte_d = KEY_CHARS[idx_q];
      obv_d   = 1'b1;
      ofe_d   = 1'b0;
      ocut_d  = 1'b0;
      olen_d  = '0;
      olast_d = stuffed_q && done;
      idx_d   = 4'(idx_q + 4'd1);
      cnt_d   = cnt_inc;
    end else if (cmd_i.load_byte) begin
      ovld_d  = 1'b1;
      obyte_d = byte_q;
      obv_d   = 1'b1;
      ofe_d   = 1'b0;
      ocut_d  = 1'b0;
      olen_d  = '0;
      olast_d = 1'b1;
      cnt_d   = cnt_inc;
    end else if (cmd_i.load_term) begin
      ovld_d  = 1'b1;
      obyte_d = 8'h00;
      obv_d   = 1'b0;
      ofe_d   = !cut_q;
      ocut_d  = cut_q;
      olen_d  = OUT_LEN_W'(cnt_q);
      olast_d = 1'b1;
      cnt_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_q    <= 4'd0;
      len_q  <= 4'd0;
      idx_q  <= 4'd0;
      cnt_q  <= '0;
      ovld_q <= 1'b0;
    end else begin
      m_q    <= m_d;
      len_q  <= len_d;
      idx_q  <= idx_d;
      cnt_q  <= cnt_d;
      ovld_q <= ovld_d;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      byte_q    <= data_byte_i;
      cut_q     <= end_of_stream_i;
      stuffed_q <= !end_of_stream_i && !hit && (data_byte_i == STUFF_CHAR)
                   && (m_q == KEY_LAST);
    end
    obyte_q <= obyte_d;
    obv_q   <= obv_d;
    ofe_q   <= ofe_d;
    ocut_q  <= ocut_d;
    olast_q <= olast_d;
    olen_q  <= olen_d;
  end

  assign out_valid_o   = ovld_q;
  assign out_byte_o    = obyte_q;
  assign byte_valid_o  = obv_q;
  assign file_end_o    = ofe_q;
  assign stream_cut_o  = ocut_q;
  assign file_length_o = olen_q;
  assign last_o        = olast_q;

endmodule

// File: hdl/skfd_ctrl.sv
// ----------------------------------------------------------------------------
// skfd_ctrl: controller of the key-file destuffer
// Accepts one input beat at a time and sequences the replay, byte and
// terminator beats into the output register.
// ----------------------------------------------------------------------------
module skfd_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 out_ready_i,
  input  skfd_pkg::skfd_sts_t  sts_i,
  output skfd_pkg::skfd_cmd_t  cmd_o
);
  import skfd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_REPLAY = 4'b0010,
    S_BYTE   = 4'b0100,
    S_TERM   = 4'b1000
  } skfd_state_e;

  skfd_state_e state_q, state_d;
  logic        out_free;

  assign out_free = !sts_i.out_busy || out_ready_i;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.is_eos || sts_i.full_match) begin
            state_d = S_TERM;
          end else if (sts_i.partial) begin
            state_d = S_IDLE;
          end else if (sts_i.stuff || sts_i.m_nz) begin
            state_d = S_REPLAY;
          end else begin
            state_d = S_BYTE;
          end
        end
      end
      S_REPLAY: begin
        if (out_free) begin
          cmd_o.load_replay = 1'b1;
          if (sts_i.replay_done) begin
            state_d = sts_i.stuffed ? S_IDLE : S_BYTE;
          end
        end
      end
      S_BYTE: begin
        if (out_free) begin
          cmd_o.load_byte = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_TERM: begin
        if (out_free) begin
          cmd_o.load_term = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: hdl/stuffed_key_file_destuffer_unit.sv
// ----------------------------------------------------------------------------
// stuffed_key_file_destuffer_unit: terminator-key file destuffer
// Strips a file framed by a fixed twelve-character terminator key with
// X-stuffing from a received byte stream and reports file end or stream cut
// with the length.
// ----------------------------------------------------------------------------
//  channel | signals                                        | dir
//  --------+------------------------------------------------+-----
//  in      | in_valid_i/in_ready_o, data_byte_i,            | in
//          | end_of_stream_i                                |
//  out     | out_valid_o/out_ready_i, out_byte_o,           | out
//          | byte_valid_o, file_end_o, stream_cut_o,        |
//          | file_length_o, last_o                          |
//
// A prefix-matching byte causes no result beat, so in_ready_o stays high.
// The controller loads the result beats of an input, up to 12, into the
// output register in turn and keeps in_ready_o low until all are loaded.
// The output register lets the next input be taken while a result waits.
// Back pressure on out stalls the replay, byte and terminator sequencing.
// Reset (rst_ni low, async) clears the match and length counters, the output valid flag and the controller state.
// ----------------------------------------------------------------------------
module stuffed_key_file_destuffer_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [7:0]                         data_byte_i,
  input  logic                               end_of_stream_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [7:0]                         out_byte_o,
  output logic                               byte_valid_o,
  output logic                               file_end_o,
  output logic                               stream_cut_o,
  output logic [skfd_pkg::OUT_LEN_W-1:0]     file_length_o,
  output logic                               last_o
);
  import skfd_pkg::*;

  skfd_cmd_t cmd;
  skfd_sts_t sts;

  // sequencer: one item at a time, one result beat per cycle while the output is free
  skfd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // counters, key compare, replay index and output register
  skfd_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .data_byte_i     (data_byte_i),
    .end_of_stream_i (end_of_stream_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .out_byte_o      (out_byte_o),
    .byte_valid_o    (byte_valid_o),
    .file_end_o      (file_end_o),
    .stream_cut_o    (stream_cut_o),
    .file_length_o   (file_length_o),
    .last_o          (last_o)
  );

endmodule
